// File: rtl/core/text_terminal_char_buffer_assert.svh
// assertion macros shared by the character buffer checker
`ifndef TEXT_TERMINAL_CHAR_BUFFER_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_BUFFER_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define TTCB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define TTCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ttcb_pkg.sv
// types and constants of the text terminal character buffer
package ttcb_pkg;

    // commands carried by an input item
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } ttcb_cmd_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_MEM,
        ST_RDATA,
        ST_GLYPH,
        ST_CLEAR,
        ST_DONE
    } ttcb_state_t;

    // configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // configuration reset values
    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET    = 6'd25;

    // character codes
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] TILDE_CODE   = 8'h7E;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] RETURN_CODE  = 8'd13;
    localparam logic [7:0] GLYPH_SPAN   = TILDE_CODE - SPACE_CODE;

    // font atlas layout and divide-by-ten reciprocal (exact for values up to 179)
    localparam logic [6:0] ATLAS_PER_ROW = 7'd10;
    localparam logic [7:0] RECIP_TEN     = 8'd205;
    localparam int         RECIP_SHIFT   = 11;

endpackage

// File: rtl/core/text_terminal_char_buffer.sv
// text terminal character buffer with cursor, memory and glyph lookup
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------
//  input    | s_valid / s_ready | s_command, s_char_code, s_target_col/_row
//  result   | m_valid / m_ready | m_cell_char, m_glyph_*, m_cursor_col/_row
//  config   | cfg_we            | cfg_index, cfg_wdata
//
// newline, carriage return and move go from idle to done; put of a character
// passes the multiply, add and memory states; read may go on through the
// read-data, multiply and glyph states: one multiplier is shared by the cell
// address and the atlas divide, and the cell memory has one registered read port.
// clear writes every cell, one cell written per cycle. after reset a clearing
// pass fills the store with spaces; s_ready stays low meanwhile. a stalled result
// holds the sequencer in its last state only once the next item has run up to it.
module text_terminal_char_buffer #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    // input items
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_char_code,
    input  logic [6:0] s_target_col,
    input  logic [4:0] s_target_row,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_cell_char,
    output logic       m_glyph_valid,
    output logic [3:0] m_glyph_col,
    output logic [3:0] m_glyph_row,
    output logic [6:0] m_cursor_col,
    output logic [4:0] m_cursor_row
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // control registers
    ttcb_pkg::ttcb_state_t state_reg, state_next;
    logic [7:0]        columns_in_use_reg, columns_in_use_next;
    logic [5:0]        rows_in_use_reg, rows_in_use_next;
    logic [6:0]        cur_x_reg, cur_x_next;
    logic [4:0]        cur_y_reg, cur_y_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              m_valid_reg, m_valid_next;

    // payload registers
    ttcb_pkg::ttcb_cmd_t cmd_reg, cmd_next;
    logic [7:0]        ch_reg, ch_next;
    logic [6:0]        tc_reg, tc_next;
    logic [4:0]        tr_reg, tr_next;
    logic [6:0]        mul_a_reg, mul_a_next;
    logic [7:0]        mul_b_reg, mul_b_next;
    logic [14:0]       prod_reg, prod_next;
    logic              glyph_phase_reg, glyph_phase_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              hit_reg, hit_next;
    logic [6:0]        g_reg, g_next;
    logic [7:0]        res_cell_reg, res_cell_next;
    logic              res_valid_reg, res_valid_next;
    logic [3:0]        res_gcol_reg, res_gcol_next;
    logic [3:0]        res_grow_reg, res_grow_next;
    logic [7:0]        out_cell_reg, out_cell_next;
    logic              out_gvalid_reg, out_gvalid_next;
    logic [3:0]        out_gcol_reg, out_gcol_next;
    logic [3:0]        out_grow_reg, out_grow_next;
    logic [6:0]        out_cx_reg, out_cx_next;
    logic [4:0]        out_cy_reg, out_cy_next;

    // cell memory
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    // effective grid size
    logic [7:0] cols_eff;
    logic [5:0] rows_eff;

    // datapath helpers
    logic [15:0] idx_sum;
    logic        tgt_in_grid;
    logic        cur_in_grid;
    logic        in_grid;
    logic [7:0]  x_inc;
    logic [5:0]  y_inc;
    logic [7:0]  g_full;
    logic [3:0]  grow_q;
    logic [6:0]  tens;
    logic        out_free;

    // clamp configured grid size
    always_comb begin
        if (columns_in_use_reg == 8'd0) begin
            cols_eff = 8'd1;
        end else if ({1'b0, columns_in_use_reg} > 9'(MAX_COLS)) begin
            cols_eff = 8'(MAX_COLS);
        end else begin
            cols_eff = columns_in_use_reg;
        end
        if (rows_in_use_reg == 6'd0) begin
            rows_eff = 6'd1;
        end else if ({2'b00, rows_in_use_reg} > 8'(MAX_ROWS)) begin
            rows_eff = 6'(MAX_ROWS);
        end else begin
            rows_eff = rows_in_use_reg;
        end
    end

    assign s_ready       = (state_reg == ttcb_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_cell_char   = out_cell_reg;
    assign m_glyph_valid = out_gvalid_reg;
    assign m_glyph_col   = out_gcol_reg;
    assign m_glyph_row   = out_grow_reg;
    assign m_cursor_col  = out_cx_reg;
    assign m_cursor_row  = out_cy_reg;

    assign out_free = !m_valid_reg || m_ready;

    // next state and datapath
    always_comb begin
        state_next          = state_reg;
        columns_in_use_next = columns_in_use_reg;
        rows_in_use_next    = rows_in_use_reg;
        cur_x_next          = cur_x_reg;
        cur_y_next          = cur_y_reg;
        clr_cnt_next        = clr_cnt_reg;
        m_valid_next        = m_valid_reg;
        cmd_next            = cmd_reg;
        ch_next             = ch_reg;
        tc_next             = tc_reg;
        tr_next             = tr_reg;
        mul_a_next          = mul_a_reg;
        mul_b_next          = mul_b_reg;
        prod_next           = prod_reg;
        glyph_phase_next    = glyph_phase_reg;
        addr_next           = addr_reg;
        hit_next            = hit_reg;
        g_next              = g_reg;
        res_cell_next       = res_cell_reg;
        res_valid_next      = res_valid_reg;
        res_gcol_next       = res_gcol_reg;
        res_grow_next       = res_grow_reg;
        out_cell_next       = out_cell_reg;
        out_gvalid_next     = out_gvalid_reg;
        out_gcol_next       = out_gcol_reg;
        out_grow_next       = out_grow_reg;
        out_cx_next         = out_cx_reg;
        out_cy_next         = out_cy_reg;
        mem_we              = 1'b0;
        mem_re              = 1'b0;
        mem_waddr           = clr_cnt_reg;
        mem_wdata           = ttcb_pkg::SPACE_CODE;

        tgt_in_grid = ({1'b0, s_target_col} < cols_eff) && ({1'b0, s_target_row} < rows_eff);
        cur_in_grid = ({1'b0, cur_x_reg} < cols_eff) && ({1'b0, cur_y_reg} < rows_eff);
        in_grid     = (cmd_reg == ttcb_pkg::CMD_READ)
                    ? (({1'b0, tc_reg} < cols_eff) && ({1'b0, tr_reg} < rows_eff))
                    : cur_in_grid;
        idx_sum     = {1'b0, prod_reg} + ((cmd_reg == ttcb_pkg::CMD_READ)
                    ? {9'd0, tc_reg} : {9'd0, cur_x_reg});
        x_inc       = {1'b0, cur_x_reg} + 8'd1;
        y_inc       = {1'b0, cur_y_reg} + 6'd1;
        g_full      = rdata_reg - ttcb_pkg::SPACE_CODE;
        grow_q      = prod_reg[ttcb_pkg::RECIP_SHIFT +: 4];
        tens        = 7'({3'd0, grow_q} * ttcb_pkg::ATLAS_PER_ROW);

        // release the output register once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                ttcb_pkg::CFG_COLUMNS: columns_in_use_next = cfg_wdata;
                ttcb_pkg::CFG_ROWS:    rows_in_use_next    = cfg_wdata[5:0];
                default:               ;
            endcase
        end

        case (state_reg)
            // fill the store with spaces after reset
            ttcb_pkg::ST_INIT: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    clr_cnt_next = '0;
                    state_next   = ttcb_pkg::ST_IDLE;
                end
            end

            // take an item and dispatch on its command
            ttcb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next         = ttcb_pkg::ttcb_cmd_t'(s_command);
                    ch_next          = s_char_code;
                    tc_next          = s_target_col;
                    tr_next          = s_target_row;
                    glyph_phase_next = 1'b0;
                    res_cell_next    = 8'd0;
                    res_valid_next   = 1'b0;
                    res_gcol_next    = 4'd0;
                    res_grow_next    = 4'd0;
                    mul_b_next       = cols_eff;
                    case (ttcb_pkg::ttcb_cmd_t'(s_command))
                        ttcb_pkg::CMD_PUT: begin
                            if (s_char_code == ttcb_pkg::NEWLINE_CODE) begin
                                cur_y_next = (y_inc >= rows_eff) ? 5'd0 : y_inc[4:0];
                                state_next = ttcb_pkg::ST_DONE;
                            end else if (s_char_code == ttcb_pkg::RETURN_CODE) begin
                                cur_x_next = 7'd0;
                                state_next = ttcb_pkg::ST_DONE;
                            end else begin
                                mul_a_next = {2'b00, cur_y_reg};
                                state_next = ttcb_pkg::ST_MUL;
                            end
                        end
                        ttcb_pkg::CMD_MOVE: begin
                            if (tgt_in_grid) begin
                                cur_x_next = s_target_col;
                                cur_y_next = s_target_row;
                            end
                            state_next = ttcb_pkg::ST_DONE;
                        end
                        ttcb_pkg::CMD_CLEAR: begin
                            cur_x_next   = 7'd0;
                            cur_y_next   = 5'd0;
                            clr_cnt_next = '0;
                            state_next   = ttcb_pkg::ST_CLEAR;
                        end
                        ttcb_pkg::CMD_READ: begin
                            mul_a_next = {2'b00, s_target_row};
                            state_next = ttcb_pkg::ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end

            // shared multiplier: row times columns, or glyph index times reciprocal
            ttcb_pkg::ST_MUL: begin
                prod_next  = {7'd0, mul_a_reg} * {7'd0, mul_b_reg};
                state_next = glyph_phase_reg ? ttcb_pkg::ST_GLYPH : ttcb_pkg::ST_ADD;
            end

            // cell address and range check
            ttcb_pkg::ST_ADD: begin
                addr_next  = idx_sum[ADDR_W-1:0];
                hit_next   = in_grid && (32'(idx_sum) < DEPTH);
                state_next = ttcb_pkg::ST_MEM;
            end

            // memory access; put also advances the cursor
            ttcb_pkg::ST_MEM: begin
                mem_waddr = addr_reg;
                mem_wdata = ch_reg;
                if (cmd_reg == ttcb_pkg::CMD_READ) begin
                    mem_re     = hit_reg;
                    state_next = hit_reg ? ttcb_pkg::ST_RDATA : ttcb_pkg::ST_DONE;
                end else begin
                    mem_we = hit_reg;
                    if (x_inc >= cols_eff) begin
                        cur_x_next = 7'd0;
                        if (y_inc >= rows_eff) begin
                            cur_y_next = 5'd0;
                        end else begin
                            cur_y_next = y_inc[4:0];
                        end
                    end else begin
                        cur_x_next = x_inc[6:0];
                        if ({1'b0, cur_y_reg} >= rows_eff) begin
                            cur_y_next = 5'd0;
                            cur_x_next = 7'd0;
                        end
                    end
                    state_next = ttcb_pkg::ST_DONE;
                end
            end

            // read data back; printable characters go on to the atlas divide
            ttcb_pkg::ST_RDATA: begin
                res_cell_next = rdata_reg;
                if (rdata_reg >= ttcb_pkg::SPACE_CODE && g_full <= ttcb_pkg::GLYPH_SPAN) begin
                    res_valid_next   = 1'b1;
                    g_next           = g_full[6:0];
                    mul_a_next       = g_full[6:0];
                    mul_b_next       = ttcb_pkg::RECIP_TEN;
                    glyph_phase_next = 1'b1;
                    state_next       = ttcb_pkg::ST_MUL;
                end else begin
                    state_next = ttcb_pkg::ST_DONE;
                end
            end

            // atlas row is the quotient, column the remainder
            ttcb_pkg::ST_GLYPH: begin
                res_grow_next = grow_q;
                res_gcol_next = 4'(g_reg - tens);
                state_next    = ttcb_pkg::ST_DONE;
            end

            // clear command sweep
            ttcb_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    clr_cnt_next = '0;
                    state_next   = ttcb_pkg::ST_DONE;
                end
            end

            // hand the result to the output register
            ttcb_pkg::ST_DONE: begin
                if (out_free) begin
                    out_cell_next   = res_cell_reg;
                    out_gvalid_next = res_valid_reg;
                    out_gcol_next   = res_gcol_reg;
                    out_grow_next   = res_grow_reg;
                    out_cx_next     = cur_x_reg;
                    out_cy_next     = cur_y_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ttcb_pkg::ST_IDLE;
                end
            end

            default: state_next = ttcb_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ttcb_pkg::ST_INIT;
            columns_in_use_reg <= ttcb_pkg::COLUMNS_RESET;
            rows_in_use_reg    <= ttcb_pkg::ROWS_RESET;
            cur_x_reg          <= 7'd0;
            cur_y_reg          <= 5'd0;
            clr_cnt_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            columns_in_use_reg <= columns_in_use_next;
            rows_in_use_reg    <= rows_in_use_next;
            cur_x_reg          <= cur_x_next;
            cur_y_reg          <= cur_y_next;
            clr_cnt_reg        <= clr_cnt_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        ch_reg          <= ch_next;
        tc_reg          <= tc_next;
        tr_reg          <= tr_next;
        mul_a_reg       <= mul_a_next;
        mul_b_reg       <= mul_b_next;
        prod_reg        <= prod_next;
        glyph_phase_reg <= glyph_phase_next;
        addr_reg        <= addr_next;
        hit_reg         <= hit_next;
        g_reg           <= g_next;
        res_cell_reg    <= res_cell_next;
        res_valid_reg   <= res_valid_next;
        res_gcol_reg    <= res_gcol_next;
        res_grow_reg    <= res_grow_next;
        out_cell_reg    <= out_cell_next;
        out_gvalid_reg  <= out_gvalid_next;
        out_gcol_reg    <= out_gcol_next;
        out_grow_reg    <= out_grow_next;
        out_cx_reg      <= out_cx_next;
        out_cy_reg      <= out_cy_next;
    end

    // cell memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[addr_reg];
        end
    end

endmodule

// File: rtl/core/ttcb_checker.sv
// port-level checker of the character buffer and its bind
`include "text_terminal_char_buffer_assert.svh"

module ttcb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_cell_char,
    input logic       m_glyph_valid,
    input logic [3:0] m_glyph_col,
    input logic [3:0] m_glyph_row
);

    logic [7:0] glyph_index;
    logic [7:0] atlas_index;

    // atlas position recombined into a glyph index
    assign glyph_index = m_cell_char - 8'h20;
    assign atlas_index = 8'({4'd0, m_glyph_row} * 8'd10) + {4'd0, m_glyph_col};

    // an accepted item drops input ready in the cycle after it is taken
    `TTCB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready,
        "input ready right after an accepted item")

    // a stalled result holds its payload
    `TTCB_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_cell_char) && $stable(m_glyph_col) && $stable(m_glyph_row),
        "stalled result changed")

    // no glyph means zero atlas position
    `TTCB_ASSERT_SAME(a_no_glyph_zero, aclk, aresetn, m_valid && !m_glyph_valid,
        m_glyph_col == 4'd0 && m_glyph_row == 4'd0, "atlas position without glyph")

    // a glyph is printable and its column is below ten
    `TTCB_ASSERT_SAME(a_glyph_printable, aclk, aresetn, m_valid && m_glyph_valid,
        m_cell_char >= 8'h20 && m_cell_char <= 8'h7E && m_glyph_col <= 4'd9,
        "glyph outside printable range")

    // atlas position matches the character
    `TTCB_ASSERT_SAME(a_glyph_position, aclk, aresetn, m_valid && m_glyph_valid,
        atlas_index == glyph_index, "atlas position does not match character")

endmodule

bind text_terminal_char_buffer ttcb_checker u_ttcb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_cell_char   (m_cell_char),
    .m_glyph_valid (m_glyph_valid),
    .m_glyph_col   (m_glyph_col),
    .m_glyph_row   (m_glyph_row)
);

// File: sim/tb_text_terminal_char_buffer.sv
// testbench of the text terminal character buffer: directed script, random commands, shadow store
`timescale 1ns / 100ps

module tb_text_terminal_char_buffer;

    localparam int GRID_MAX_COLS = 128;
    localparam int GRID_MAX_ROWS = 32;
    localparam int STORE_CELLS   = GRID_MAX_COLS * GRID_MAX_ROWS;
    localparam int PHASE_ITEMS   = 125;
    localparam int SCRIPT_LEN    = 25;
    localparam int PHASES        = 9;

    // one result item, field for field
    typedef struct packed {
        logic [7:0] cell_char;
        logic       glyph_valid;
        logic [3:0] glyph_col;
        logic [3:0] glyph_row;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
    } cell_result_t;

    // one row of the directed script; fixed rows carry their result typed in
    typedef struct packed {
        ttcb_pkg::ttcb_cmd_t cmd;
        logic [7:0]          ch;
        logic [6:0]          col;
        logic [4:0]          row;
        logic                fixed;
        cell_result_t        want;
    } script_row_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_we        = 1'b0;
    logic       cfg_index     = ttcb_pkg::CFG_COLUMNS;
    logic [7:0] cfg_wdata     = 8'd0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_command     = ttcb_pkg::CMD_PUT;
    logic [7:0] s_char_code   = 8'd0;
    logic [6:0] s_target_col  = 7'd0;
    logic [4:0] s_target_row  = 5'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_cell_char;
    logic       m_glyph_valid;
    logic [3:0] m_glyph_col;
    logic [3:0] m_glyph_row;
    logic [6:0] m_cursor_col;
    logic [4:0] m_cursor_row;

    // shadow copy of the block's state and registers
    logic [7:0] shadow_cells [STORE_CELLS];
    int         shadow_x;
    int         shadow_y;
    logic [7:0] shadow_cols_reg;
    logic [5:0] shadow_rows_reg;

    cell_result_t awaited_results [$];
    cell_result_t got_res;
    cell_result_t want_res;
    int           fail_count   = 0;
    int           results_seen = 0;
    int           burst_left   = 0;

    // receiver stall pattern
    int mode_left = 0;
    int ready_mode = 0;
    int hold_left = 0;
    bit held_once = 1'b0;

    // grid settings walked after the directed part: column and row register writes
    logic [7:0] phase_cols [PHASES] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd9, 8'd200, 8'd40,
                                        8'd3, 8'd128};
    logic [7:0] phase_rows [PHASES] = '{8'd32, 8'd1, 8'd0, 8'hFF, 8'd4, 8'd2, 8'd32,
                                        8'd20, 8'd9};

    // directed script, run on the reset grid of 80 by 25
    script_row_t directed_script [SCRIPT_LEN] = '{
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd0, 5'd0, 1'b1, '{8'h20, 1'b1, 4'd0, 4'd0, 7'd0, 5'd0}},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd127, 5'd31, 1'b1,
          '{8'h00, 1'b0, 4'd0, 4'd0, 7'd0, 5'd0}},
        '{ttcb_pkg::CMD_PUT, 8'h41, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_PUT, 8'hFF, 7'd127, 5'd31, 1'b0, '0},
        '{ttcb_pkg::CMD_PUT, 8'h00, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_PUT, 8'h7E, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_PUT, 8'h7F, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd0, 5'd0, 1'b1, '{8'h41, 1'b1, 4'd3, 4'd3, 7'd5, 5'd0}},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd1, 5'd0, 1'b1, '{8'hFF, 1'b0, 4'd0, 4'd0, 7'd5, 5'd0}},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd2, 5'd0, 1'b1, '{8'h00, 1'b0, 4'd0, 4'd0, 7'd5, 5'd0}},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd3, 5'd0, 1'b1, '{8'h7E, 1'b1, 4'd4, 4'd9, 7'd5, 5'd0}},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd4, 5'd0, 1'b1, '{8'h7F, 1'b0, 4'd0, 4'd0, 7'd5, 5'd0}},
        '{ttcb_pkg::CMD_PUT, 8'h0A, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_PUT, 8'h0D, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_MOVE, 8'h00, 7'd79, 5'd24, 1'b0, '0},
        '{ttcb_pkg::CMD_PUT, 8'h7A, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_MOVE, 8'h00, 7'd80, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_MOVE, 8'h00, 7'd0, 5'd25, 1'b0, '0},
        '{ttcb_pkg::CMD_MOVE, 8'hFF, 7'd127, 5'd31, 1'b1,
          '{8'h00, 1'b0, 4'd0, 4'd0, 7'd0, 5'd0}},
        '{ttcb_pkg::CMD_MOVE, 8'h00, 7'd5, 5'd24, 1'b0, '0},
        '{ttcb_pkg::CMD_PUT, 8'h0A, 7'd0, 5'd0, 1'b0, '0},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd79, 5'd24, 1'b0, '0},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd80, 5'd24, 1'b1,
          '{8'h00, 1'b0, 4'd0, 4'd0, 7'd5, 5'd0}},
        '{ttcb_pkg::CMD_CLEAR, 8'h55, 7'd42, 5'd21, 1'b1,
          '{8'h00, 1'b0, 4'd0, 4'd0, 7'd0, 5'd0}},
        '{ttcb_pkg::CMD_READ, 8'h00, 7'd0, 5'd0, 1'b1, '{8'h20, 1'b1, 4'd0, 4'd0, 7'd0, 5'd0}}
    };

    text_terminal_char_buffer #(
        .MAX_COLS(GRID_MAX_COLS),
        .MAX_ROWS(GRID_MAX_ROWS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_char_code   (s_char_code),
        .s_target_col  (s_target_col),
        .s_target_row  (s_target_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cell_char   (m_cell_char),
        .m_glyph_valid (m_glyph_valid),
        .m_glyph_col   (m_glyph_col),
        .m_glyph_row   (m_glyph_row),
        .m_cursor_col  (m_cursor_col),
        .m_cursor_row  (m_cursor_row)
    );

    always #6 aclk = ~aclk;

    // column and row counts in force, after clamping the registers
    function automatic int grid_cols();
        if (shadow_cols_reg == 8'd0) return 1;
        if (shadow_cols_reg > GRID_MAX_COLS) return GRID_MAX_COLS;
        return int'(shadow_cols_reg);
    endfunction

    function automatic int grid_rows();
        if (shadow_rows_reg == 6'd0) return 1;
        if (shadow_rows_reg > GRID_MAX_ROWS) return GRID_MAX_ROWS;
        return int'(shadow_rows_reg);
    endfunction

    // blank the whole store and home the cursor
    function automatic void blank_screen();
        for (int i = 0; i < STORE_CELLS; i++) shadow_cells[i] = ttcb_pkg::SPACE_CODE;
        shadow_x = 0;
        shadow_y = 0;
    endfunction

    // apply one command to the shadow state and return the result it gives
    function automatic cell_result_t apply_command(ttcb_pkg::ttcb_cmd_t cmd, logic [7:0] ch,
                                                   logic [6:0] tc, logic [4:0] tr);
        int           cols;
        int           rows;
        logic [7:0]   b;
        logic [7:0]   g;
        cell_result_t r;
        cols = grid_cols();
        rows = grid_rows();
        r = '0;
        case (cmd)
            ttcb_pkg::CMD_PUT: begin
                if (ch == ttcb_pkg::NEWLINE_CODE) begin
                    shadow_y++;
                    if (shadow_y >= rows) shadow_y = 0;
                end else if (ch == ttcb_pkg::RETURN_CODE) begin
                    shadow_x = 0;
                end else begin
                    // a cursor left outside a shrunk grid writes nothing but still moves
                    if (shadow_x < cols && shadow_y < rows)
                        shadow_cells[shadow_y * cols + shadow_x] = ch;
                    shadow_x++;
                    if (shadow_x >= cols) begin
                        shadow_x = 0;
                        shadow_y++;
                    end
                    if (shadow_y >= rows) begin
                        shadow_x = 0;
                        shadow_y = 0;
                    end
                end
            end
            ttcb_pkg::CMD_MOVE: begin
                if (int'(tc) < cols && int'(tr) < rows) begin
                    shadow_x = int'(tc);
                    shadow_y = int'(tr);
                end
            end
            ttcb_pkg::CMD_CLEAR: blank_screen();
            default: begin
                if (int'(tc) < cols && int'(tr) < rows) begin
                    b = shadow_cells[int'(tr) * cols + int'(tc)];
                    g = b - ttcb_pkg::SPACE_CODE;
                    r.cell_char = b;
                    if (b >= ttcb_pkg::SPACE_CODE && g <= ttcb_pkg::GLYPH_SPAN) begin
                        r.glyph_valid = 1'b1;
                        r.glyph_col   = 4'(g % ttcb_pkg::ATLAS_PER_ROW);
                        r.glyph_row   = 4'(g / ttcb_pkg::ATLAS_PER_ROW);
                    end
                end
            end
        endcase
        r.cursor_col = 7'(shadow_x);
        r.cursor_row = 5'(shadow_y);
        return r;
    endfunction

    // offer one item in bursts with random gaps, then record its result
    task automatic offer(ttcb_pkg::ttcb_cmd_t cmd, logic [7:0] ch, logic [6:0] tc,
                         logic [4:0] tr, logic fixed, cell_result_t want);
        int           gap;
        cell_result_t res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge aclk);
                s_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid      = 1'b1;
        s_command    = cmd;
        s_char_code  = ch;
        s_target_col = tc;
        s_target_row = tr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = apply_command(cmd, ch, tc, tr);
        if (fixed) res = want;
        awaited_results.push_back(res);
    endtask

    // one random command, mostly aimed inside the grid
    task automatic random_item();
        int                  pick;
        int                  sub;
        ttcb_pkg::ttcb_cmd_t cmd;
        logic [7:0]          ch;
        logic [6:0]          tc;
        logic [4:0]          tr;
        pick = $urandom_range(0, 199);
        ch = 8'($urandom_range(0, 255));
        tc = 7'($urandom_range(0, 127));
        tr = 5'($urandom_range(0, 31));
        if (pick < 3) begin
            cmd = ttcb_pkg::CMD_CLEAR;
        end else if (pick < 95) begin
            cmd = ttcb_pkg::CMD_PUT;
            sub = $urandom_range(0, 9);
            if (sub == 0) ch = ttcb_pkg::NEWLINE_CODE;
            else if (sub == 1) ch = ttcb_pkg::RETURN_CODE;
            else if (sub > 2)
                ch = 8'($urandom_range(ttcb_pkg::SPACE_CODE, ttcb_pkg::TILDE_CODE));
        end else begin
            cmd = (pick < 130) ? ttcb_pkg::CMD_MOVE : ttcb_pkg::CMD_READ;
            if ($urandom_range(0, 5) != 0) begin
                tc = 7'($urandom_range(0, grid_cols() - 1));
                tr = 5'($urandom_range(0, grid_rows() - 1));
            end
        end
        offer(cmd, ch, tc, tr, 1'b0, '0);
    endtask

    // stop offering and wait until every result is in
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // write both grid registers while the block is idle
    task automatic program_grid(logic [7:0] cols, logic [7:0] rows);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = ttcb_pkg::CFG_COLUMNS;
        cfg_wdata = cols;
        @(negedge aclk);
        cfg_index = ttcb_pkg::CFG_ROWS;
        cfg_wdata = rows;
        @(negedge aclk);
        cfg_we = 1'b0;
        shadow_cols_reg = cols;
        shadow_rows_reg = rows[5:0];
    endtask

    // stimulus
    initial begin
        shadow_cols_reg = ttcb_pkg::COLUMNS_RESET;
        shadow_rows_reg = ttcb_pkg::ROWS_RESET;
        blank_screen();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
            offer(directed_script[i].cmd, directed_script[i].ch, directed_script[i].col,
                  directed_script[i].row, directed_script[i].fixed, directed_script[i].want);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            program_grid(phase_cols[p], phase_rows[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) random_item();
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // receiver: changing stall pattern, plus one long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (!held_once && results_seen >= 300) begin
            held_once = 1'b1;
            hold_left = 400;
            m_ready   = 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(32, 256);
            end
            mode_left--;
            case (ready_mode)
                0:       m_ready = 1'b1;
                1:       m_ready = 1'($urandom_range(0, 1));
                default: m_ready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // compare each accepted result with the oldest awaited one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_res = '{m_cell_char, m_glyph_valid, m_glyph_col, m_glyph_row,
                        m_cursor_col, m_cursor_row};
            if (awaited_results.size() == 0) begin
                $error("result item with none awaited: cell_char %0d", m_cell_char);
                fail_count++;
            end else begin
                want_res = awaited_results.pop_front();
                check_field("cell_char", want_res.cell_char, got_res.cell_char);
                check_field("glyph_valid", want_res.glyph_valid, got_res.glyph_valid);
                check_field("glyph_col", want_res.glyph_col, got_res.glyph_col);
                check_field("glyph_row", want_res.glyph_row, got_res.glyph_row);
                check_field("cursor_col", want_res.cursor_col, got_res.cursor_col);
                check_field("cursor_row", want_res.cursor_row, got_res.cursor_row);
            end
            results_seen++;
        end
    end

    // watchdog
    initial begin
        #15ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ttcb_pkg.sv
rtl/core/text_terminal_char_buffer.sv
rtl/core/ttcb_checker.sv
sim/tb_text_terminal_char_buffer.sv
